// ----- hw/rtl/pte_arb_pkg.sv -----
// shared types, constants and policy lookup for the intent arbiter
`default_nettype none
package pte_arb_pkg;
	localparam int QueueDepth = 8;
	localparam int TypeCount = 7;
	localparam int PosW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	localparam logic [1:0] StEnq = 2'd0;
	localparam logic [1:0] StFull = 2'd1;
	localparam logic [1:0] StDisp = 2'd2;
	localparam logic [1:0] StNone = 2'd3;

	typedef struct packed {
		logic [1:0] prio;
		logic [9:0] throttle;
		logic [12:0] expire;
	} policy_t;

	function automatic policy_t policy_of(input logic [2:0] kind);
		policy_t p;
		case (kind)
			3'd0: p = '{2'd2, 10'd250, 13'd5000};
			3'd1: p = '{2'd3, 10'd250, 13'd5000};
			3'd2: p = '{2'd2, 10'd250, 13'd5000};
			3'd3: p = '{2'd3, 10'd500, 13'd8000};
			3'd4: p = '{2'd3, 10'd500, 13'd8000};
			3'd5: p = '{2'd1, 10'd750, 13'd8000};
			3'd6: p = '{2'd1, 10'd750, 13'd5000};
			default: p = '{2'd1, 10'd250, 13'd0};
		endcase
		return p;
	endfunction

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input beat
		logic enq;       // append entry
		logic exp_step;  // examine entry at scan position for expiry
		logic sel_init;  // start best search
		logic sel_step;  // examine entry at scan position for best
		logic rm_best;   // remove chosen entry, record dispatch
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_sel;
		logic scan_done;
	} stat_t;
endpackage
`default_nettype wire

// ----- hw/rtl/pte_arb_dp.sv -----
// datapath: queue storage, expiry sweep, best search and result register
`default_nettype none
module pte_arb_dp (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire pte_arb_pkg::cmd_t cmd,
	output pte_arb_pkg::stat_t stat,
	input  wire logic req_type,
	input  wire logic [31:0] now_ms,
	input  wire logic [2:0] intent_kind,
	input  wire logic [15:0] intent_arg,
	output logic [1:0] status,
	output logic [2:0] out_kind,
	output logic [15:0] out_arg,
	output logic [3:0] dropped_count
);
	localparam int D = pte_arb_pkg::QueueDepth;
	localparam int T = pte_arb_pkg::TypeCount;

	logic [pte_arb_pkg::CntW-1:0] count_q, pos_q;
	logic [2:0] kind_q [D];
	logic [15:0] pay_q [D];
	logic [31:0] time_q [D];
	logic [31:0] last_q [T];
	logic req_q;
	logic [31:0] now_q;
	logic [2:0] ikind_q;
	logic [15:0] iarg_q;
	logic [3:0] drop_q;
	logic found_q;
	logic [1:0] bprio_q;
	logic [31:0] btime_q;
	logic [pte_arb_pkg::PosW-1:0] best_q;

	logic [pte_arb_pkg::PosW-1:0] pidx;
	pte_arb_pkg::policy_t pol;
	logic [31:0] age, last, since;
	logic expired, throttled, better;

	// examine the entry at the scan position
	always_comb begin
		pidx = pos_q[pte_arb_pkg::PosW-1:0];
		pol = pte_arb_pkg::policy_of(kind_q[pidx]);
		age = now_q - time_q[pidx];
		expired = (pol.expire != '0) && (age > {19'd0, pol.expire});
		last = (32'(kind_q[pidx]) < 32'(T)) ? last_q[kind_q[pidx]] : 32'd0;
		since = now_q - last;
		throttled = (pol.throttle != '0) && (last != '0) && (since < {22'd0, pol.throttle});
		better = !found_q || (pol.prio > bprio_q) ||
			((pol.prio == bprio_q) && (time_q[pidx] < btime_q));
	end

	assign stat.is_sel = req_q;
	assign stat.scan_done = (pos_q >= count_q);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q <= '0;
			found_q <= 1'b0;
			drop_q <= '0;
			for (int k = 0; k < T; k++) last_q[k] <= '0;
		end else begin
			if (cmd.load) begin
				pos_q <= '0;
				drop_q <= '0;
			end
			if (cmd.enq && count_q < pte_arb_pkg::CntW'(D)) count_q <= count_q + 1'b1;
			if (cmd.exp_step) begin
				if (expired) begin
					count_q <= count_q - 1'b1;
					if (drop_q != 4'hf) drop_q <= drop_q + 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (cmd.sel_init) begin
				pos_q <= '0;
				found_q <= 1'b0;
			end
			if (cmd.sel_step) begin
				pos_q <= pos_q + 1'b1;
				if (!throttled && better) found_q <= 1'b1;
			end
			if (cmd.rm_best && found_q) begin
				count_q <= count_q - 1'b1;
				if (32'(kind_q[best_q]) < 32'(T)) last_q[kind_q[best_q]] <= now_q;
			end
		end
	end

	// payload registers and queue shifting
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			now_q <= now_ms;
			ikind_q <= intent_kind;
			iarg_q <= intent_arg;
		end
		if (cmd.enq && count_q < pte_arb_pkg::CntW'(D)) begin
			kind_q[count_q[pte_arb_pkg::PosW-1:0]] <= ikind_q;
			pay_q[count_q[pte_arb_pkg::PosW-1:0]] <= iarg_q;
			time_q[count_q[pte_arb_pkg::PosW-1:0]] <= now_q;
		end
		if (cmd.exp_step && expired) begin
			for (int k = 0; k < D - 1; k++) begin
				if (k >= int'(pidx)) begin
					kind_q[k] <= kind_q[k+1];
					pay_q[k] <= pay_q[k+1];
					time_q[k] <= time_q[k+1];
				end
			end
		end
		if (cmd.sel_step && !throttled && better) begin
			bprio_q <= pol.prio;
			btime_q <= time_q[pidx];
			best_q <= pidx;
		end
		if (cmd.rm_best) begin
			if (found_q) begin
				status <= pte_arb_pkg::StDisp;
				out_kind <= kind_q[best_q];
				out_arg <= pay_q[best_q];
				for (int k = 0; k < D - 1; k++) begin
					if (k >= int'(best_q)) begin
						kind_q[k] <= kind_q[k+1];
						pay_q[k] <= pay_q[k+1];
						time_q[k] <= time_q[k+1];
					end
				end
			end else begin
				status <= pte_arb_pkg::StNone;
				out_kind <= '0;
				out_arg <= '0;
			end
			dropped_count <= drop_q;
		end
		if (cmd.enq) begin
			status <= (count_q < pte_arb_pkg::CntW'(D)) ? pte_arb_pkg::StEnq
				: pte_arb_pkg::StFull;
			out_kind <= '0;
			out_arg <= '0;
			dropped_count <= '0;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/pte_arb_ctrl.sv -----
// controller: sequences enqueue, expiry sweep, selection and output handshake
`default_nettype none
module pte_arb_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  wire logic out_stall,
	input  wire pte_arb_pkg::stat_t stat,
	output pte_arb_pkg::cmd_t cmd
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DEC  = 6'b000010,
		S_EXP  = 6'b000100,
		S_SEL  = 6'b001000,
		S_RM   = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// accept only when idle: no beat in progress and no result pending
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.load = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				if (stat.is_sel) state_d = S_EXP;
				else begin
					cmd.enq = 1'b1;
					state_d = S_OUT;
				end
			end
			S_EXP: begin
				if (stat.scan_done) begin
					cmd.sel_init = 1'b1;
					state_d = S_SEL;
				end else cmd.exp_step = 1'b1;
			end
			S_SEL: begin
				if (stat.scan_done) state_d = S_RM;
				else cmd.sel_step = 1'b1;
			end
			S_RM: begin
				cmd.rm_best = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/priority_throttle_expiry_arbiter_top.sv -----
// Intent arbiter top level: controller plus queue datapath.
// Enqueue: the beat is loaded, appended in S_DEC, and the result is valid in S_OUT.
// Select: the beat passes through S_DEC, the sweep in S_EXP, the search in S_SEL and S_RM to S_OUT.
// One beat in flight; next beat taken once the result beat is accepted, sweep and search 1 entry/cycle.
// Async active-low reset empties the queue and clears all dispatch times.
`default_nettype none
module priority_throttle_expiry_arbiter_top (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic req_type,
	input  wire logic [31:0] now_ms,
	input  wire logic [2:0] intent_kind,
	input  wire logic [15:0] intent_arg,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [1:0] status,
	output logic [2:0] out_kind,
	output logic [15:0] out_arg,
	output logic [3:0] dropped_count
);
	pte_arb_pkg::cmd_t cmd;
	pte_arb_pkg::stat_t stat;

	pte_arb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
	);

	pte_arb_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.req_type(req_type), .now_ms(now_ms), .intent_kind(intent_kind),
		.intent_arg(intent_arg), .status(status), .out_kind(out_kind),
		.out_arg(out_arg), .dropped_count(dropped_count)
	);
endmodule
`default_nettype wire
